### hw/rtl/hpg_pkg.sv
package hpg_pkg;

	localparam int PHASE_BITS_DEF   = 32;
	localparam int CORDIC_STEPS_DEF = 16;

	localparam int POS_W    = 20;
	localparam int STEP_W   = 24;
	localparam int RAD_W    = 16;
	localparam int CTR_W    = 12;
	localparam int CORD_W   = 34;
	localparam int ANG_W    = 32;
	localparam int DIVN_W   = 40;
	localparam int PEN_W    = 18;
	localparam int SCL_A_W  = 19;
	localparam int SUM_W    = 25;
	localparam int APB_AW   = 5;
	localparam int APB_DW   = 32;

	localparam logic [CORD_W-1:0] GAIN_Q30 = CORD_W'(652032874);

	localparam logic [RAD_W-1:0] OUTER_RST = 16'd6400;
	localparam logic [RAD_W-1:0] INNER_RST = 16'd1600;
	localparam logic [RAD_W-1:0] RATIO_RST = 16'd11469;
	localparam logic [CTR_W-1:0] CX_RST    = 12'd400;
	localparam logic [CTR_W-1:0] CY_RST    = 12'd300;

	localparam logic [2:0] REG_OUTER = 3'd0;
	localparam logic [2:0] REG_INNER = 3'd1;
	localparam logic [2:0] REG_RATIO = 3'd2;
	localparam logic [2:0] REG_CX    = 3'd3;
	localparam logic [2:0] REG_CY    = 3'd4;

	localparam logic OP_ADVANCE = 1'b0;
	localparam logic OP_RESTART = 1'b1;

	// arctan(2^-i) in units of 2^-32 turn
	function automatic logic [ANG_W-1:0] atan_turn(input logic [4:0] i);
		logic [ANG_W-1:0] r;
		unique case (i)
			5'd0:  r = 32'd536870912;
			5'd1:  r = 32'd316933406;
			5'd2:  r = 32'd167458907;
			5'd3:  r = 32'd85004756;
			5'd4:  r = 32'd42667331;
			5'd5:  r = 32'd21354465;
			5'd6:  r = 32'd10679838;
			5'd7:  r = 32'd5340245;
			5'd8:  r = 32'd2670163;
			5'd9:  r = 32'd1335087;
			5'd10: r = 32'd667544;
			5'd11: r = 32'd333772;
			5'd12: r = 32'd166886;
			5'd13: r = 32'd83443;
			5'd14: r = 32'd41722;
			5'd15: r = 32'd20861;
			5'd16: r = 32'd10430;
			5'd17: r = 32'd5215;
			5'd18: r = 32'd2608;
			5'd19: r = 32'd1304;
			5'd20: r = 32'd652;
			5'd21: r = 32'd326;
			5'd22: r = 32'd163;
			5'd23: r = 32'd81;
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [SUM_W-1:0] v);
		logic signed [SUM_W-1:0] hi;
		logic signed [SUM_W-1:0] lo;
		hi = SUM_W'(524287);
		lo = -SUM_W'(524288);
		if (v > hi) begin
			return POS_W'(hi);
		end else if (v < lo) begin
			return POS_W'(lo);
		end
		return v[POS_W-1:0];
	endfunction

endpackage

### hw/rtl/hpg_if.sv
interface hpg_in_if;
	import hpg_pkg::*;
	logic              valid;
	logic              ready;
	logic              operation;
	logic [STEP_W-1:0] time_step;
	modport source(output valid, operation, time_step, input ready);
	modport sink(input valid, operation, time_step, output ready);
endinterface

interface hpg_out_if;
	import hpg_pkg::*;
	logic                    valid;
	logic                    ready;
	logic signed [POS_W-1:0] pen_x;
	logic signed [POS_W-1:0] pen_y;
	logic signed [POS_W-1:0] prev_pen_x;
	logic signed [POS_W-1:0] prev_pen_y;
	logic signed [POS_W-1:0] rolling_x;
	logic signed [POS_W-1:0] rolling_y;
	logic                    first_point;
	logic                    bad_radius;
	modport source(output valid, pen_x, pen_y, prev_pen_x, prev_pen_y, rolling_x, rolling_y,
		first_point, bad_radius, input ready);
	modport sink(input valid, pen_x, pen_y, prev_pen_x, prev_pen_y, rolling_x, rolling_y,
		first_point, bad_radius, output ready);
endinterface

### hw/rtl/hpg_smul.sv
// Serial signed multiplier: one bit of a per cycle, shift-and-add.
module hpg_smul #(
	parameter int A_W = 17,
	parameter int B_W = 17
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic signed [A_W-1:0]      a,
	input  logic signed [B_W-1:0]      b,
	output logic                       busy,
	output logic signed [A_W+B_W-1:0]  p
);
	localparam int PW    = A_W + B_W;
	localparam int CNT_W = $clog2(A_W);

	logic [A_W-1:0]   a_q;
	logic [PW-1:0]    b_q;
	logic [PW-1:0]    acc_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             last;

	assign last = (cnt_q == CNT_W'(A_W - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (last) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= PW'(b);
			acc_q <= '0;
		end else if (busy_q) begin
			a_q <= a_q >> 1;
			b_q <= b_q << 1;
			// sign bit of a carries negative weight
			if (a_q[0]) begin
				acc_q <= last ? acc_q - b_q : acc_q + b_q;
			end
		end
	end

	assign busy = busy_q;
	assign p    = acc_q;
endmodule

### hw/rtl/hpg_sdiv.sv
// Restoring divider, one quotient bit per cycle.
module hpg_sdiv #(
	parameter int N_W = 40,
	parameter int D_W = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [N_W-1:0] num,
	input  logic [D_W-1:0] den,
	output logic           busy,
	output logic [N_W-1:0] quo
);
	localparam int CNT_W = $clog2(N_W);

	logic [N_W-1:0]   n_q;
	logic [D_W-1:0]   d_q;
	logic [D_W-1:0]   rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic [D_W:0]     shifted;
	logic [D_W:0]     trial;
	logic             fits;

	assign shifted = {rem_q, n_q[N_W-1]};
	assign trial   = shifted - {1'b0, d_q};
	assign fits    = (shifted >= {1'b0, d_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(N_W - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// dividend shifts out on the left, quotient bits enter on the right
	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= num;
			d_q   <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? trial[D_W-1:0] : shifted[D_W-1:0];
			n_q   <= {n_q[N_W-2:0], fits};
		end
	end

	assign busy = busy_q;
	assign quo  = n_q;
endmodule

### hw/rtl/hpg_cordic.sv
// Rotation-mode CORDIC, one micro-rotation per cycle.
module hpg_cordic #(
	parameter int STEPS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [hpg_pkg::ANG_W-1:0]          phase,
	output logic                               busy,
	output logic signed [hpg_pkg::CORD_W-1:0]  cos_v,
	output logic signed [hpg_pkg::CORD_W-1:0]  sin_v
);
	import hpg_pkg::*;

	localparam int CNT_W = $clog2(STEPS);

	logic signed [CORD_W-1:0] x_q, y_q, z_q;
	logic [CNT_W-1:0]         cnt_q;
	logic                     busy_q;
	logic                     flip_q;
	logic [ANG_W-1:0]         a_m;
	logic                     fold;
	logic [ANG_W-1:0]         a_f;
	logic signed [CORD_W-1:0] xs, ys, at;

	// angles in the left half-plane are turned by half a turn
	assign a_m  = phase - 32'h4000_0000;
	assign fold = !a_m[ANG_W-1];
	assign a_f  = fold ? (phase ^ 32'h8000_0000) : phase;

	assign xs = x_q >>> cnt_q;
	assign ys = y_q >>> cnt_q;
	assign at = CORD_W'(atan_turn(5'(cnt_q)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(STEPS - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= GAIN_Q30;
			y_q    <= '0;
			z_q    <= CORD_W'(signed'(a_f));
			flip_q <= fold;
		end else if (busy_q) begin
			if (!z_q[CORD_W-1]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end
		end
	end

	assign busy  = busy_q;
	assign cos_v = flip_q ? -x_q : x_q;
	assign sin_v = flip_q ? -y_q : y_q;
endmodule

### hw/rtl/hypotrochoid_point_generator.sv
// Advance item: accepted in S_IDLE, then multiply (S_MUL), phase-ratio divide (S_DIV),
//   phase update, CORDIC and scaling; the divide is skipped when the inner radius is zero.
// Items are not overlapped: in_ch.ready stays low until the current item is done; a restart
//   item skips the divide. The serial divider and bit-serial multipliers set the pace.
// Reset (arst_n low, async): registers take their defaults, phases clear, and a
//   phase-zero pass runs with in_ch.ready low.
module hypotrochoid_point_generator #(
	parameter int PHASE_BITS   = hpg_pkg::PHASE_BITS_DEF,
	parameter int CORDIC_STEPS = hpg_pkg::CORDIC_STEPS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	hpg_in_if.sink                      in_ch,
	hpg_out_if.source                   out_ch,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [hpg_pkg::APB_AW-1:0]  paddr,
	input  logic [hpg_pkg::APB_DW-1:0]  pwdata,
	output logic [hpg_pkg::APB_DW-1:0]  prdata,
	output logic                        pready
);
	import hpg_pkg::*;

	localparam int DLW = (PHASE_BITS > DIVN_W) ? PHASE_BITS : DIVN_W;
	localparam int SW  = (PHASE_BITS > STEP_W) ? PHASE_BITS : STEP_W;
	localparam int SPW = SCL_A_W + CORD_W;
	localparam int SRW = SPW - 30;

	// sequencer states
	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_START = 4'd1;
	localparam logic [3:0] S_MUL   = 4'd2;
	localparam logic [3:0] S_DIV   = 4'd3;
	localparam logic [3:0] S_PH    = 4'd4;
	localparam logic [3:0] S_CST   = 4'd5;
	localparam logic [3:0] S_CORD  = 4'd6;
	localparam logic [3:0] S_SC    = 4'd7;
	localparam logic [3:0] S_SCW   = 4'd8;
	localparam logic [3:0] S_DONE  = 4'd9;

	logic [3:0] state_q;

	// configuration registers
	logic [RAD_W-1:0] outer_q, inner_q, ratio_q;
	logic [CTR_W-1:0] cx_q, cy_q;
	logic             wr_en;
	logic [2:0]       widx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign widx   = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outer_q <= OUTER_RST;
			inner_q <= INNER_RST;
			ratio_q <= RATIO_RST;
			cx_q    <= CX_RST;
			cy_q    <= CY_RST;
		end else if (wr_en) begin
			unique case (widx)
				REG_OUTER: outer_q <= pwdata[RAD_W-1:0];
				REG_INNER: inner_q <= pwdata[RAD_W-1:0];
				REG_RATIO: ratio_q <= pwdata[RAD_W-1:0];
				REG_CX:    cx_q    <= pwdata[CTR_W-1:0];
				REG_CY:    cy_q    <= pwdata[CTR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (widx)
			REG_OUTER: prdata = APB_DW'(outer_q);
			REG_INNER: prdata = APB_DW'(inner_q);
			REG_RATIO: prdata = APB_DW'(ratio_q);
			REG_CX:    prdata = APB_DW'(cx_q);
			REG_CY:    prdata = APB_DW'(cy_q);
			default:   prdata = '0;
		endcase
	end

	// item latch and state
	logic                  op_q;
	logic [STEP_W-1:0]     step_q;
	logic [PHASE_BITS-1:0] outer_ph_q, inner_ph_q;
	logic                  has_q;
	logic [PEN_W-1:0]      pen_len_q;
	logic                  in_fire;

	assign in_ch.ready = (state_q == S_IDLE);
	assign in_fire     = in_ch.valid && in_ch.ready;

	// derived geometry
	logic                    r_zero, r_big;
	logic [RAD_W-1:0]        mag;
	logic signed [RAD_W:0]   arm;

	assign r_zero = (inner_q == '0);
	assign r_big  = (inner_q > outer_q);
	assign mag    = r_big ? (inner_q - outer_q) : (outer_q - inner_q);
	assign arm    = signed'({1'b0, outer_q}) - signed'({1'b0, inner_q});

	// step * |R - r| and pen_ratio * r, bit-serial
	logic                           mul_start;
	logic                           m0_busy, m1_busy;
	logic signed [RAD_W+STEP_W+1:0] m0_p;
	logic signed [2*RAD_W+1:0]      m1_p;

	hpg_smul #(.A_W(RAD_W + 1), .B_W(STEP_W + 1)) u_mul_step (
		.clk(clk), .arst_n(arst_n), .start(mul_start),
		.a(signed'({1'b0, mag})), .b(signed'({1'b0, step_q})),
		.busy(m0_busy), .p(m0_p)
	);

	hpg_smul #(.A_W(RAD_W + 1), .B_W(RAD_W + 1)) u_mul_pen (
		.clk(clk), .arst_n(arst_n), .start(mul_start),
		.a(signed'({1'b0, ratio_q})), .b(signed'({1'b0, inner_q})),
		.busy(m1_busy), .p(m1_p)
	);

	// inner phase increment = floor(step * |R - r| / r), negated when r > R
	logic              div_start, div_busy;
	logic [DIVN_W-1:0] quo;

	hpg_sdiv #(.N_W(DIVN_W), .D_W(RAD_W)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num(m0_p[DIVN_W-1:0]), .den(inner_q),
		.busy(div_busy), .quo(quo)
	);

	logic [DLW-1:0] delta;
	logic [SW-1:0]  step_ext;

	assign delta    = r_big ? (DLW'(0) - DLW'(quo)) : DLW'(quo);
	assign step_ext = SW'(step_q);

	// phase reduced to a 32-bit turn fraction
	logic [ANG_W-1:0] outer_a, inner_a;

	generate
		if (PHASE_BITS >= ANG_W) begin : g_ph_top
			assign outer_a = outer_ph_q[PHASE_BITS-1 -: ANG_W];
			assign inner_a = inner_ph_q[PHASE_BITS-1 -: ANG_W];
		end else begin : g_ph_shl
			assign outer_a = {outer_ph_q, {(ANG_W - PHASE_BITS){1'b0}}};
			assign inner_a = {inner_ph_q, {(ANG_W - PHASE_BITS){1'b0}}};
		end
	endgenerate

	logic                     cord_start, co_busy, ci_busy;
	logic signed [CORD_W-1:0] co, so, ci, si;

	hpg_cordic #(.STEPS(CORDIC_STEPS)) u_cord_outer (
		.clk(clk), .arst_n(arst_n), .start(cord_start), .phase(outer_a),
		.busy(co_busy), .cos_v(co), .sin_v(so)
	);

	hpg_cordic #(.STEPS(CORDIC_STEPS)) u_cord_inner (
		.clk(clk), .arst_n(arst_n), .start(cord_start), .phase(inner_a),
		.busy(ci_busy), .cos_v(ci), .sin_v(si)
	);

	// four radius * trig products
	logic                      sc_start;
	logic                      ax_busy, ay_busy, px_busy, py_busy;
	logic signed [SPW-1:0]     ax_p, ay_p, px_p, py_p;
	logic signed [SCL_A_W-1:0] arm_a, pen_a;

	assign arm_a = SCL_A_W'(arm);
	assign pen_a = signed'({1'b0, pen_len_q});

	hpg_smul #(.A_W(SCL_A_W), .B_W(CORD_W)) u_sc_ax (
		.clk(clk), .arst_n(arst_n), .start(sc_start), .a(arm_a), .b(co),
		.busy(ax_busy), .p(ax_p)
	);
	hpg_smul #(.A_W(SCL_A_W), .B_W(CORD_W)) u_sc_ay (
		.clk(clk), .arst_n(arst_n), .start(sc_start), .a(arm_a), .b(so),
		.busy(ay_busy), .p(ay_p)
	);
	hpg_smul #(.A_W(SCL_A_W), .B_W(CORD_W)) u_sc_px (
		.clk(clk), .arst_n(arst_n), .start(sc_start), .a(pen_a), .b(ci),
		.busy(px_busy), .p(px_p)
	);
	hpg_smul #(.A_W(SCL_A_W), .B_W(CORD_W)) u_sc_py (
		.clk(clk), .arst_n(arst_n), .start(sc_start), .a(pen_a), .b(si),
		.busy(py_busy), .p(py_p)
	);

	// round half up, then drop the 30 fraction bits
	logic [SPW-1:0]        rnd;
	logic [SPW-1:0]        ax_r, ay_r, px_r, py_r;
	logic signed [SUM_W-1:0] cxs, cys, axs, ays, pxs, pys;
	logic signed [SUM_W-1:0] rx_sum, ry_sum, px_sum, py_sum;

	assign rnd  = SPW'(1) << 29;
	assign ax_r = ax_p + rnd;
	assign ay_r = ay_p + rnd;
	assign px_r = px_p + rnd;
	assign py_r = py_p + rnd;
	assign axs  = SUM_W'(signed'(ax_r[SPW-1:30]));
	assign ays  = SUM_W'(signed'(ay_r[SPW-1:30]));
	assign pxs  = SUM_W'(signed'(px_r[SPW-1:30]));
	assign pys  = SUM_W'(signed'(py_r[SPW-1:30]));
	assign cxs  = signed'(SUM_W'({cx_q, 6'b0}));
	assign cys  = signed'(SUM_W'({cy_q, 6'b0}));

	assign rx_sum = cxs + axs;
	assign ry_sum = cys + ays;
	assign px_sum = rx_sum + pxs;
	assign py_sum = ry_sum - pys;

	// output register
	logic                    out_valid_q;
	logic signed [POS_W-1:0] pen_x_q, pen_y_q, prev_x_q, prev_y_q, roll_x_q, roll_y_q;
	logic signed [POS_W-1:0] last_x_q, last_y_q;
	logic                    first_q, bad_q;
	logic                    can_emit, emit;

	assign can_emit = !out_valid_q || out_ch.ready;
	assign emit     = (state_q == S_DONE) && can_emit && (op_q == OP_ADVANCE);

	assign mul_start  = (state_q == S_START);
	assign div_start  = (state_q == S_MUL) && !m0_busy && !m1_busy
		&& (op_q == OP_ADVANCE) && !r_zero;
	assign cord_start = (state_q == S_CST);
	assign sc_start   = (state_q == S_SC);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_START;
			op_q       <= OP_RESTART;
			outer_ph_q <= '0;
			inner_ph_q <= '0;
			has_q      <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						op_q    <= in_ch.operation;
						state_q <= S_START;
					end
				end
				S_START: begin
					if (op_q == OP_RESTART) begin
						outer_ph_q <= '0;
						inner_ph_q <= '0;
						has_q      <= 1'b0;
					end
					state_q <= S_MUL;
				end
				S_MUL: begin
					if (!m0_busy && !m1_busy) begin
						state_q <= div_start ? S_DIV : S_PH;
					end
				end
				S_DIV: begin
					if (!div_busy) begin
						state_q <= S_PH;
					end
				end
				S_PH: begin
					if (op_q == OP_ADVANCE) begin
						outer_ph_q <= outer_ph_q + step_ext[PHASE_BITS-1:0];
						if (!r_zero) begin
							inner_ph_q <= inner_ph_q + delta[PHASE_BITS-1:0];
						end
					end
					state_q <= S_CST;
				end
				S_CST: state_q <= S_CORD;
				S_CORD: begin
					if (!co_busy && !ci_busy) begin
						state_q <= S_SC;
					end
				end
				S_SC: state_q <= S_SCW;
				S_SCW: begin
					if (!ax_busy && !ay_busy && !px_busy && !py_busy) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					// a restart only refreshes the stored pen point
					if (op_q == OP_RESTART) begin
						state_q <= S_IDLE;
					end else if (can_emit) begin
						has_q   <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			step_q <= in_ch.time_step;
		end
		// pen length = ratio * r >> 14, up to 18 bits
		if ((state_q == S_MUL) && !m0_busy && !m1_busy) begin
			pen_len_q <= r_zero ? '0 : m1_p[PEN_W+13:14];
		end
		if ((state_q == S_DONE) && (op_q == OP_RESTART)) begin
			last_x_q <= sat_pos(px_sum);
			last_y_q <= sat_pos(py_sum);
		end
		if (emit) begin
			pen_x_q  <= sat_pos(px_sum);
			pen_y_q  <= sat_pos(py_sum);
			roll_x_q <= sat_pos(rx_sum);
			roll_y_q <= sat_pos(ry_sum);
			prev_x_q <= last_x_q;
			prev_y_q <= last_y_q;
			first_q  <= !has_q;
			bad_q    <= r_zero;
			last_x_q <= sat_pos(px_sum);
			last_y_q <= sat_pos(py_sum);
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.pen_x       = pen_x_q;
	assign out_ch.pen_y       = pen_y_q;
	assign out_ch.prev_pen_x  = prev_x_q;
	assign out_ch.prev_pen_y  = prev_y_q;
	assign out_ch.rolling_x   = roll_x_q;
	assign out_ch.rolling_y   = roll_y_q;
	assign out_ch.first_point = first_q;
	assign out_ch.bad_radius  = bad_q;

	// zero inner radius leaves no pen offset: pen point equals rolling center
	a_bad_radius_pen : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && bad_q |-> (pen_x_q == roll_x_q) && (pen_y_q == roll_y_q))
		else $error("pen offset nonzero with zero inner radius");

	// divider never started with a zero divisor
	a_div_nonzero : assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !r_zero)
		else $error("divide by zero radius");

	// step multiplier, divider, outer CORDIC and arm-x scaler are idle while the block waits for an item
	a_idle_quiet : assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !m0_busy && !div_busy && !co_busy && !ax_busy)
		else $error("unit busy in idle");

	// a restart item never produces a result
	a_restart_silent : assert property (@(posedge clk) disable iff (!arst_n)
		(op_q == OP_RESTART) && !out_valid_q |=> !out_valid_q)
		else $error("result raised by restart");
endmodule
